FILE: sv/rffs_pkg.sv
package rffs_pkg;

    // Fixed field widths of the item and result words
    localparam int INDEX_W = 10;
    localparam int VALUE_W = 31;
    localparam int OP_W    = 2;

    typedef logic [OP_W-1:0]    t_opcode;
    typedef logic [INDEX_W-1:0] t_index;
    typedef logic [VALUE_W-1:0] t_value;

    // Opcodes; the fourth code is a no-op
    localparam t_opcode OP_WRITE = 2'd0;
    localparam t_opcode OP_FIND  = 2'd1;
    localparam t_opcode OP_FILL  = 2'd2;

endpackage

FILE: sv/rffs_mem.sv
module rffs_mem
    import rffs_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_value        i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_value        o_rd_data
);

    t_value r_mem [DEPTH];
    t_value r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/range_fill_find_first_store.sv
// Channel  Direction  Handshake                  Word
// in       input      i_in_valid / o_in_stall    opcode, first_index, last_index, value
// out      output     o_out_valid / i_out_stall  found, position
//
// One item at a time, walking the value memory one entry per cycle.
// A write or fill walks its entries; a query walks its range and ends
// early when a match is seen; an empty range goes straight to the result.
// After reset a clearing pass writes zero to all DEPTH entries; no word
// is taken until it ends.
// A new word is taken while a finished result still waits in the output
// register; a stalled output only holds the block in its final step.
module range_fill_find_first_store
    import rffs_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_opcode i_opcode,
    input  t_index  i_first_index,
    input  t_index  i_last_index,
    input  t_value  i_value,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output logic    o_found,
    output t_index  o_position
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = ((AW > INDEX_W) ? AW : INDEX_W) + 1;
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
    localparam logic [AW-1:0] TOP_ADDR = AW'(DEPTH - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_FILL  = 3'd2;
    localparam logic [2:0] S_QUERY = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_cur, n_cur;
    logic [AW-1:0] r_last, n_last;
    t_opcode       r_op, n_op;
    t_value        r_value, n_value;
    logic          r_rd_pend, n_rd_pend;
    logic [AW-1:0] r_rd_idx, n_rd_idx;
    logic          r_res_found, n_res_found;
    t_index        r_res_pos, n_res_pos;
    logic          r_out_valid, n_out_valid;
    logic          r_found, n_found;
    t_index        r_position, n_position;

    logic          in_acc;
    logic          out_free;
    logic [CW-1:0] lo_w;
    logic [CW-1:0] hi_w;
    logic [CW-1:0] hi_c;
    logic [CW-1:0] last_w;
    logic          lo_ok;
    logic          item_live;
    logic          wr_en;
    t_value        wr_data;
    logic          rd_en;
    t_value        rd_data;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // Clip the incoming range to the store
    always_comb begin
        lo_w  = CW'(i_first_index);
        hi_w  = CW'(i_last_index);
        hi_c  = (hi_w >= DEPTH_C) ? DEPTH_C - CW'(1) : hi_w;
        lo_ok = (lo_w < DEPTH_C);
        if (i_opcode == OP_WRITE) begin
            last_w    = lo_w;
            item_live = lo_ok;
        end else begin
            last_w    = hi_c;
            item_live = lo_ok && (lo_w <= hi_c)
                        && ((i_opcode == OP_FIND) || (i_opcode == OP_FILL));
        end
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_last      = r_last;
        n_op        = r_op;
        n_value     = r_value;
        n_rd_pend   = 1'b0;
        n_rd_idx    = r_rd_idx;
        n_res_found = r_res_found;
        n_res_pos   = r_res_pos;
        n_out_valid = r_out_valid;
        n_found     = r_found;
        n_position  = r_position;

        // result taken downstream
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                if (r_cur == TOP_ADDR) begin
                    n_cur   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_cur = AW'(r_cur + 1'b1);
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_op        = i_opcode;
                    n_value     = i_value;
                    n_cur       = AW'(lo_w);
                    n_last      = AW'(last_w);
                    n_res_found = 1'b0;
                    n_res_pos   = '0;
                    if (!item_live) begin
                        n_state = S_DONE;
                    end else if (i_opcode == OP_FIND) begin
                        n_state = S_QUERY;
                    end else begin
                        n_state = S_FILL;
                    end
                end
            end
            S_FILL: begin
                if (r_cur == r_last) begin
                    n_state = S_DONE;
                end else begin
                    n_cur = AW'(r_cur + 1'b1);
                end
            end
            S_QUERY: begin
                // issue the next read, check the one that returned
                n_rd_pend = 1'b1;
                n_rd_idx  = r_cur;
                if (r_cur != r_last) begin
                    n_cur = AW'(r_cur + 1'b1);
                end
                if (r_rd_pend) begin
                    if (rd_data == r_value) begin
                        n_res_found = 1'b1;
                        n_res_pos   = INDEX_W'(r_rd_idx);
                        n_rd_pend   = 1'b0;
                        n_state     = S_DONE;
                    end else if (r_rd_idx == r_last) begin
                        n_rd_pend = 1'b0;
                        n_state   = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_found     = r_res_found;
                    n_position  = r_res_pos;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cur       <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_last      <= n_last;
        r_op        <= n_op;
        r_value     <= n_value;
        r_rd_idx    <= n_rd_idx;
        r_res_found <= n_res_found;
        r_res_pos   <= n_res_pos;
        r_found     <= n_found;
        r_position  <= n_position;
    end

    // Memory access: clear and fill write, query reads
    assign wr_en   = (r_state == S_CLEAR) || (r_state == S_FILL);
    assign wr_data = (r_state == S_CLEAR) ? '0 : r_value;
    assign rd_en   = (r_state == S_QUERY);

    rffs_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_cur),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_cur),
        .o_rd_data (rd_data)
    );

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_position  = r_position;

`ifndef SYNTH
    // no result leaves while the store is being cleared
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_out_valid)
        else $error("result word during clearing pass");

    // fill pointer never passes the range end
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> (r_cur <= r_last))
        else $error("fill pointer beyond range end");

    // a returned read always lies inside the query range
    a_read_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QUERY && r_rd_pend) |-> (r_rd_idx <= r_last))
        else $error("query read beyond range end");

    // only a query can report a match
    a_found_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_res_found) |-> (r_op == OP_FIND))
        else $error("match reported for a non-query word");
`endif

endmodule

FILE: dv/rffs_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the store, predicts each result word from the
// accepted item words and compares it with what comes out.
module rffs_checker
    import rffs_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_stall,
    input  t_opcode i_opcode,
    input  t_index  i_first_index,
    input  t_index  i_last_index,
    input  t_value  i_value,
    input  logic    i_out_valid,
    input  logic    i_out_stall,
    input  logic    i_found,
    input  t_index  i_position,
    output int      o_pending,
    output int      o_errors
);

    typedef struct packed {
        logic   found;
        t_index position;
    } t_result;

    // Shadow copy of the value memory and the results still owed
    t_value  mem_image [DEPTH];
    t_result expected_results [$];
    int      err_count = 0;

    // Apply one item to the shadow memory and return the word it must produce
    function automatic t_result predict_result(t_opcode op, t_index first_in,
                                               t_index last_in, t_value val);
        t_result r;
        int      lo;
        int      hi;
        int      i;
        r  = '0;
        lo = int'(first_in);
        hi = int'(last_in);
        // range end saturates at the top of the store
        if (hi >= DEPTH) begin
            hi = DEPTH - 1;
        end
        case (op)
            OP_WRITE: begin
                if (lo < DEPTH) begin
                    mem_image[lo] = val;
                end
            end
            OP_FIND: begin
                // a reversed or out-of-store range never enters the loop
                if (lo < DEPTH) begin
                    for (i = lo; i <= hi && !r.found; i++) begin
                        if (mem_image[i] == val) begin
                            r.found    = 1'b1;
                            r.position = t_index'(i);
                        end
                    end
                end
            end
            OP_FILL: begin
                if (lo < DEPTH) begin
                    for (i = lo; i <= hi; i++) begin
                        mem_image[i] = val;
                    end
                end
            end
            default: begin
                // unused opcode: no change, zero result
            end
        endcase
        return r;
    endfunction

    task automatic log_mismatch(string what, t_result want, t_result got);
        if (err_count < 10) begin
            $display("%0t %s: expected found=%0b position=%0d, got found=%0b position=%0d",
                     $time, what, want.found, want.position, got.found, got.position);
        end
        err_count++;
    endtask

    // Result side first, then item side; a result never leaves on the edge
    // its own item is taken
    always @(posedge i_clk) begin : track
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            foreach (mem_image[k]) begin
                mem_image[k] = '0;
            end
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got.found    = i_found;
                got.position = i_position;
                if (expected_results.size() == 0) begin
                    log_mismatch("result word with none expected", '0, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got.found !== want.found || got.position !== want.position) begin
                        log_mismatch("result word mismatch", want, got);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_results.push_back(predict_result(i_opcode, i_first_index,
                                                          i_last_index, i_value));
            end
        end
        o_pending <= expected_results.size();
        o_errors  <= err_count;
    end

endmodule

FILE: dv/tb_range_fill_find_first_store.sv
`timescale 1ns / 1ps

module tb_range_fill_find_first_store
    import rffs_pkg::*;
();

    localparam int      DEPTH        = 1024;
    localparam int      RANDOM_WORDS = 580;
    localparam int      HOLD_CYCLES  = 3000;
    localparam t_opcode OP_UNUSED    = 2'd3;
    localparam t_index  TOP_INDEX    = 10'd1023;
    localparam t_value  MAX_VALUE    = 31'h7FFF_FFFF;
    localparam t_value  PAT_A        = 31'h2AAA_AAAA;
    localparam t_value  PAT_B        = 31'h1555_5555;

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    i_in_valid;
    logic    o_in_stall;
    t_opcode i_opcode;
    t_index  i_first_index;
    t_index  i_last_index;
    t_value  i_value;
    logic    o_out_valid;
    logic    i_out_stall;
    logic    o_found;
    t_index  o_position;

    int      pending_words;
    int      error_count;
    logic    long_hold;
    t_value  value_pool [8];

    range_fill_find_first_store #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_first_index(i_first_index),
        .i_last_index (i_last_index),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_found      (o_found),
        .o_position   (o_position)
    );

    rffs_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_first_index(i_first_index),
        .i_last_index (i_last_index),
        .i_value      (i_value),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_found      (o_found),
        .i_position   (o_position),
        .o_pending    (pending_words),
        .o_errors     (error_count)
    );

    always #5 i_clk = ~i_clk;

    // Offer one word and hold it until the block takes it
    task automatic send_word(t_opcode op, t_index first_idx, t_index last_idx, t_value val);
        i_in_valid    <= 1'b1;
        i_opcode      <= op;
        i_first_index <= first_idx;
        i_last_index  <= last_idx;
        i_value       <= val;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
    endtask

    // Stop offering and wait for every owed result word
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Mostly short ranges near a hot window and values from a small pool,
    // so that queries hit; a few wide and reversed ranges
    task automatic random_word(output t_opcode op, output t_index first_idx,
                               output t_index last_idx, output t_value val);
        int r;
        int lo;
        int hi;
        r  = $urandom_range(0, 99);
        op = (r < 30) ? OP_WRITE : (r < 55) ? OP_FILL : (r < 95) ? OP_FIND : OP_UNUSED;
        lo = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 127) : $urandom_range(0, 1023);
        r  = $urandom_range(0, 99);
        if (r < 6) begin
            lo = $urandom_range(1, 1023);
            hi = $urandom_range(0, lo - 1);
        end else if (r < 10) begin
            lo = $urandom_range(0, 15);
            hi = $urandom_range(1008, 1023);
        end else begin
            hi = lo + $urandom_range(0, 31);
            if (hi > 1023) begin
                hi = 1023;
            end
        end
        first_idx = t_index'(lo);
        last_idx  = t_index'(hi);
        val = ($urandom_range(0, 4) == 0) ? t_value'($urandom()) :
                                            value_pool[$urandom_range(0, 7)];
    endtask

    // Receiver: stall segments of varying density, plus one long hold-off
    initial begin : out_stall_gen
        int  seg_left;
        int  mode;
        bit  held;
        seg_left = 0;
        mode     = 0;
        held     = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold && !held) begin
                held = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    mode     = $urandom_range(0, 3);
                    seg_left = $urandom_range(10, 150);
                end
                seg_left--;
                case (mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 99) < 30);
                    2: i_out_stall <= ($urandom_range(0, 99) < 70);
                    default: i_out_stall <= seg_left[2];
                endcase
            end
        end
    end

    initial begin : stimulus
        int      n_sent;
        int      burst_left;
        int      gap;
        bit      paused;
        t_opcode op;
        t_index  lo;
        t_index  hi;
        t_value  v;
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_opcode      <= OP_WRITE;
        i_first_index <= '0;
        i_last_index  <= '0;
        i_value       <= '0;
        long_hold     <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: cleared store, field extremes, empty ranges, unused opcode
        send_word(OP_FIND,   10'd0,     TOP_INDEX, '0);
        send_word(OP_FIND,   10'd0,     TOP_INDEX, MAX_VALUE);
        send_word(OP_WRITE,  TOP_INDEX, 10'd0,     MAX_VALUE);
        send_word(OP_FIND,   10'd0,     TOP_INDEX, MAX_VALUE);
        send_word(OP_FIND,   TOP_INDEX, TOP_INDEX, MAX_VALUE);
        send_word(OP_FILL,   10'd0,     TOP_INDEX, PAT_A);
        send_word(OP_FIND,   10'd0,     TOP_INDEX, '0);
        send_word(OP_FIND,   10'd512,   TOP_INDEX, PAT_A);
        send_word(OP_FILL,   10'd10,    10'd5,     PAT_B);
        send_word(OP_FIND,   TOP_INDEX, 10'd0,     PAT_A);
        send_word(OP_FIND,   10'd0,     TOP_INDEX, PAT_B);
        send_word(OP_WRITE,  10'd0,     TOP_INDEX, '0);
        send_word(OP_FIND,   10'd0,     TOP_INDEX, '0);
        send_word(OP_UNUSED, 10'd0,     TOP_INDEX, MAX_VALUE);
        send_word(OP_FIND,   10'd0,     TOP_INDEX, MAX_VALUE);
        send_word(OP_FILL,   10'd100,   10'd200,   PAT_B);
        send_word(OP_FIND,   10'd0,     TOP_INDEX, PAT_B);
        send_word(OP_WRITE,  10'd300,   10'd0,     PAT_B);
        send_word(OP_FIND,   10'd201,   TOP_INDEX, PAT_B);
        send_word(OP_FILL,   TOP_INDEX, TOP_INDEX, '0);
        send_word(OP_FIND,   10'd1,     TOP_INDEX, '0);
        send_word(OP_WRITE,  10'h2AA,   10'h155,   MAX_VALUE);
        send_word(OP_FIND,   10'h155,   TOP_INDEX, MAX_VALUE);
        wait_drained();

        // Random part in bursts
        value_pool[0] = '0;
        value_pool[1] = MAX_VALUE;
        for (int k = 2; k < 8; k++) begin
            value_pool[k] = t_value'($urandom());
        end
        n_sent     = 0;
        paused     = 1'b0;
        burst_left = $urandom_range(1, 16);
        while (n_sent < RANDOM_WORDS) begin
            random_word(op, lo, hi, v);
            send_word(op, lo, hi, v);
            if (op != OP_UNUSED) begin
                n_sent++;
            end
            if (n_sent == 100) begin
                long_hold <= 1'b1;
            end
            if (n_sent == 290 && !paused) begin
                paused = 1'b1;
                wait_drained();
            end else begin
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 16);
                    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) :
                                                        $urandom_range(0, 8);
                    if (gap > 0) begin
                        i_in_valid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                end
            end
        end
        wait_drained();
        repeat (50) @(posedge i_clk);

        if (error_count == 0 && pending_words == 0) begin
            $display("PASS range_fill_find_first_store");
        end else begin
            $display("FAIL range_fill_find_first_store");
        end
        $finish;
    end

    // Run limit: several times the slowest correct run
    initial begin : run_limit
        #(64'd30_000_000);
        $display("FAIL range_fill_find_first_store");
        $finish;
    end

endmodule

FILE: files.f
sv/rffs_pkg.sv
sv/rffs_mem.sv
sv/range_fill_find_first_store.sv
dv/rffs_checker.sv
dv/tb_range_fill_find_first_store.sv
